// ----- design/spdg_pkg.sv -----
// ----------------------------------------------------------------------------
// spdg_pkg: shared types and widths of the spatial pan and distance gain block
// widths of the square-root and divider lanes and the data carried alongside
// ----------------------------------------------------------------------------
package spdg_pkg;

	localparam int ONE_Q14   = 16384;
	localparam int B_W       = 15;  // clamped blend, 0..16384
	localparam int D_W       = 31;  // near / far distance when valid
	localparam int DOT_W     = 65;  // magnitude of the dot product
	localparam int SQ_REM_W  = 67;  // radicand and remainder
	localparam int SQ_ROOT_W = 33;  // square root
	localparam int PN_W      = 80;  // pan dividend (dot shifted by 14)
	localparam int PD_W      = 66;  // pan divisor (dist * rlen)
	localparam int GN_W      = 45;  // gain dividend
	localparam int GD_W      = 31;  // gain divisor
	localparam int Q_W       = 14;  // quotient bits

	typedef struct packed {
		logic [SQ_REM_W-1:0]  rem;
		logic [SQ_ROOT_W-1:0] root;
	} sq_lane_t;

	typedef struct packed {
		logic             invalid;
		logic             neg;
		logic [B_W-1:0]   b;
		logic [D_W-1:0]   near_d;
		logic [D_W-1:0]   far_d;
		logic [DOT_W-1:0] dot;
	} sq_side_t;

	typedef struct packed {
		logic [PN_W-1:0] rem;
		logic [PD_W-1:0] den;
		logic [Q_W-1:0]  q;
	} pan_lane_t;

	typedef struct packed {
		logic [GN_W-1:0] rem;
		logic [GD_W-1:0] den;
		logic [Q_W-1:0]  q;
	} gain_lane_t;

	typedef struct packed {
		logic           invalid;
		logic           neg;
		logic           zero;
		logic           sat;
		logic [1:0]     gsel;
		logic [B_W-1:0] b;
	} dv_side_t;

endpackage

// ----- design/spdg_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// spdg_sqrt_cell: one bit of two restoring square roots
// decides root bit BIT for the distance and right-vector lanes, then hands on
// ----------------------------------------------------------------------------
module spdg_sqrt_cell #(
	parameter int BIT = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  spdg_pkg::sq_side_t  in_side,
	input  spdg_pkg::sq_lane_t  in_dist,
	input  spdg_pkg::sq_lane_t  in_rlen,
	output logic                out_valid,
	output spdg_pkg::sq_side_t  out_side,
	output spdg_pkg::sq_lane_t  out_dist,
	output spdg_pkg::sq_lane_t  out_rlen
);

	localparam int RW = spdg_pkg::SQ_REM_W;
	localparam int QW = spdg_pkg::SQ_ROOT_W;

	logic               valid_q;
	spdg_pkg::sq_side_t side_q;
	spdg_pkg::sq_lane_t dist_q, rlen_q;

	function automatic spdg_pkg::sq_lane_t step(input spdg_pkg::sq_lane_t x);
		logic [RW-1:0]      trial;
		spdg_pkg::sq_lane_t y;
		trial = (RW'(x.root) << (BIT + 1)) | (RW'(1) << (2 * BIT));
		y = x;
		if (trial <= x.rem) begin
			y.rem  = x.rem - trial;
			y.root = x.root | (QW'(1) << BIT);
		end
		return y;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		side_q <= in_side;
		dist_q <= step(in_dist);
		rlen_q <= step(in_rlen);
	end

	assign out_valid = valid_q;
	assign out_side  = side_q;
	assign out_dist  = dist_q;
	assign out_rlen  = rlen_q;

endmodule

// ----- design/spdg_div_cell.sv -----
// ----------------------------------------------------------------------------
// spdg_div_cell: one quotient bit of the pan and gain long divisions
// compares the shifted divisor with the partial remainder in both lanes
// ----------------------------------------------------------------------------
module spdg_div_cell #(
	parameter int BIT = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  spdg_pkg::dv_side_t   in_side,
	input  spdg_pkg::pan_lane_t  in_pan,
	input  spdg_pkg::gain_lane_t in_gain,
	output logic                 out_valid,
	output spdg_pkg::dv_side_t   out_side,
	output spdg_pkg::pan_lane_t  out_pan,
	output spdg_pkg::gain_lane_t out_gain
);

	localparam int PW = spdg_pkg::PN_W;
	localparam int GW = spdg_pkg::GN_W;
	localparam int QW = spdg_pkg::Q_W;

	logic                 valid_q;
	spdg_pkg::dv_side_t   side_q;
	spdg_pkg::pan_lane_t  pan_q;
	spdg_pkg::gain_lane_t gain_q;

	function automatic spdg_pkg::pan_lane_t pan_step(input spdg_pkg::pan_lane_t x);
		logic [PW-1:0]       trial;
		spdg_pkg::pan_lane_t y;
		trial = PW'(x.den) << BIT;
		y = x;
		if (trial <= x.rem) begin
			y.rem = x.rem - trial;
			y.q   = x.q | (QW'(1) << BIT);
		end
		return y;
	endfunction

	function automatic spdg_pkg::gain_lane_t gain_step(input spdg_pkg::gain_lane_t x);
		logic [GW-1:0]        trial;
		spdg_pkg::gain_lane_t y;
		trial = GW'(x.den) << BIT;
		y = x;
		if (trial <= x.rem) begin
			y.rem = x.rem - trial;
			y.q   = x.q | (QW'(1) << BIT);
		end
		return y;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		side_q <= in_side;
		pan_q  <= pan_step(in_pan);
		gain_q <= gain_step(in_gain);
	end

	assign out_valid = valid_q;
	assign out_side  = side_q;
	assign out_pan   = pan_q;
	assign out_gain  = gain_q;

endmodule

// ----- design/spatial_pan_and_distance_gain_top.sv -----
// ----------------------------------------------------------------------------
// spatial_pan_and_distance_gain_top: per-voice stereo pan and distance gain
// offset, lengths, cosine pan and linear distance attenuation, fully pipelined
// ----------------------------------------------------------------------------
// A new voice beat is taken on every clock where start is high; busy never
// rises, so the block takes one beat per cycle with no gaps. Every beat gives
// exactly one result beat, shown on pan, distance_gain and params_invalid for
// one cycle with done high; the receiver cannot stall, so it must capture the
// result in that cycle. The result passes through a pipelined datapath: three
// front stages (differences, products, sums), a row of 33 square-root cells
// producing one root bit each, a multiply and a setup stage, a row of 14
// divider cells producing one quotient bit each, and the output register.
// Beats in flight never interact, as no state is carried.
// ----------------------------------------------------------------------------
module spatial_pan_and_distance_gain_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] source_x,
	input  logic signed [31:0] source_y,
	input  logic signed [31:0] listener_x,
	input  logic signed [31:0] listener_y,
	input  logic signed [31:0] right_x,
	input  logic signed [31:0] right_y,
	input  logic signed [15:0] blend,
	input  logic signed [31:0] near_distance,
	input  logic signed [31:0] far_distance,
	output logic               done,
	output logic signed [15:0] pan,
	output logic        [14:0] distance_gain,
	output logic               params_invalid
);

	localparam int BW   = spdg_pkg::B_W;
	localparam int DW   = spdg_pkg::D_W;
	localparam int OW   = spdg_pkg::DOT_W;
	localparam int RW   = spdg_pkg::SQ_REM_W;
	localparam int QW   = spdg_pkg::SQ_ROOT_W;
	localparam int PNW  = spdg_pkg::PN_W;
	localparam int PDW  = spdg_pkg::PD_W;
	localparam int GNW  = spdg_pkg::GN_W;
	localparam int DQW  = spdg_pkg::Q_W;
	localparam int LATENCY = 3 + QW + 2 + DQW + 1;

	// gain selection codes
	localparam logic [1:0] GAIN_ZERO = 2'd0;
	localparam logic [1:0] GAIN_DIV  = 2'd1;
	localparam logic [1:0] GAIN_ONE  = 2'd2;

	// the pipe never holds off a beat
	assign busy = 1'b0;

	// ---------------- stage 1: offsets, magnitudes, signs, parameter checks
	logic signed [32:0] dx_c, dy_c;
	logic        [32:0] mdx_c, mdy_c;
	logic        [31:0] mrx_c, mry_c;
	logic        [BW-1:0] b_c;
	logic               inv_c;

	always_comb begin
		dx_c  = {source_x[31], source_x} - {listener_x[31], listener_x};
		dy_c  = {source_y[31], source_y} - {listener_y[31], listener_y};
		mdx_c = dx_c[32] ? 33'(-dx_c) : 33'(dx_c);
		mdy_c = dy_c[32] ? 33'(-dy_c) : 33'(dy_c);
		mrx_c = right_x[31] ? 32'(-right_x) : 32'(right_x);
		mry_c = right_y[31] ? 32'(-right_y) : 32'(right_y);
		// blend clamped into 0..unity
		if (blend[15]) begin
			b_c = '0;
		end else if (blend > 16'sd16384) begin
			b_c = BW'(spdg_pkg::ONE_Q14);
		end else begin
			b_c = blend[BW-1:0];
		end
		inv_c = (near_distance < 0) || (far_distance <= near_distance);
	end

	logic               v_s1;
	logic        [32:0] mdx_s1, mdy_s1;
	logic        [31:0] mrx_s1, mry_s1;
	logic               sdx_s1, sdy_s1, srx_s1, sry_s1, inv_s1;
	logic      [BW-1:0] b_s1;
	logic      [DW-1:0] near_s1, far_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		mdx_s1  <= mdx_c;
		mdy_s1  <= mdy_c;
		mrx_s1  <= mrx_c;
		mry_s1  <= mry_c;
		sdx_s1  <= dx_c[32];
		sdy_s1  <= dy_c[32];
		srx_s1  <= right_x[31];
		sry_s1  <= right_y[31];
		inv_s1  <= inv_c;
		b_s1    <= b_c;
		near_s1 <= near_distance[DW-1:0];
		far_s1  <= far_distance[DW-1:0];
	end

	// ---------------- stage 2: squares and cross products
	logic          v_s2;
	logic   [65:0] sqdx_s2, sqdy_s2;
	logic   [63:0] sqrx_s2, sqry_s2;
	logic   [64:0] m1_s2, m2_s2;
	logic          n1_s2, n2_s2, inv_s2;
	logic [BW-1:0] b_s2;
	logic [DW-1:0] near_s2, far_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		sqdx_s2 <= 66'(mdx_s1) * 66'(mdx_s1);
		sqdy_s2 <= 66'(mdy_s1) * 66'(mdy_s1);
		sqrx_s2 <= 64'(mrx_s1) * 64'(mrx_s1);
		sqry_s2 <= 64'(mry_s1) * 64'(mry_s1);
		m1_s2   <= 65'(mdx_s1) * 65'(mrx_s1);
		m2_s2   <= 65'(mdy_s1) * 65'(mry_s1);
		n1_s2   <= sdx_s1 ^ srx_s1;
		n2_s2   <= sdy_s1 ^ sry_s1;
		inv_s2  <= inv_s1;
		b_s2    <= b_s1;
		near_s2 <= near_s1;
		far_s2  <= far_s1;
	end

	// ---------------- stage 3: radicands and signed dot product magnitude
	logic               v_s3;
	logic      [RW-1:0] nd_s3, nr_s3;
	spdg_pkg::sq_side_t side_s3;
	logic      [OW-1:0] dot_c;
	logic               neg_c;

	always_comb begin
		if (n1_s2 == n2_s2) begin
			dot_c = OW'(m1_s2) + OW'(m2_s2);
			neg_c = n1_s2;
		end else if (m1_s2 >= m2_s2) begin
			dot_c = OW'(m1_s2 - m2_s2);
			neg_c = n1_s2;
		end else begin
			dot_c = OW'(m2_s2 - m1_s2);
			neg_c = n2_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		nd_s3          <= RW'(sqdx_s2) + RW'(sqdy_s2);
		nr_s3          <= RW'(sqrx_s2) + RW'(sqry_s2);
		side_s3.invalid <= inv_s2;
		side_s3.neg    <= neg_c;
		side_s3.b      <= b_s2;
		side_s3.near_d <= near_s2;
		side_s3.far_d  <= far_s2;
		side_s3.dot    <= dot_c;
	end

	// ---------------- square-root row, one root bit per cell, msb first
	logic               sq_v  [0:QW];
	spdg_pkg::sq_side_t sq_sd [0:QW];
	spdg_pkg::sq_lane_t sq_d  [0:QW];
	spdg_pkg::sq_lane_t sq_r  [0:QW];

	always_comb begin
		sq_v[0]      = v_s3;
		sq_sd[0]     = side_s3;
		sq_d[0].rem  = nd_s3;
		sq_d[0].root = '0;
		sq_r[0].rem  = nr_s3;
		sq_r[0].root = '0;
	end

	for (genvar i = 0; i < QW; i++) begin : g_sqrt
		spdg_sqrt_cell #(
			.BIT(QW - 1 - i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (sq_v[i]),
			.in_side  (sq_sd[i]),
			.in_dist  (sq_d[i]),
			.in_rlen  (sq_r[i]),
			.out_valid(sq_v[i+1]),
			.out_side (sq_sd[i+1]),
			.out_dist (sq_d[i+1]),
			.out_rlen (sq_r[i+1])
		);
	end

	// ---------------- stage 4: length product
	logic               v_s4;
	logic     [PDW-1:0] den_s4;
	logic      [QW-1:0] dist_s4;
	logic               zero_s4;
	spdg_pkg::sq_side_t side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= sq_v[QW];
		end
	end

	always_ff @(posedge clk) begin
		den_s4  <= PDW'(sq_d[QW].root) * PDW'(sq_r[QW].root);
		dist_s4 <= sq_d[QW].root;
		zero_s4 <= (sq_d[QW].root == '0) || (sq_r[QW].root == '0);
		side_s4 <= sq_sd[QW];
	end

	// ---------------- stage 5: saturation check and divider set-up
	logic                 v_s5;
	spdg_pkg::dv_side_t   side_s5;
	spdg_pkg::pan_lane_t  pan_s5;
	spdg_pkg::gain_lane_t gain_s5;
	logic           [1:0] gsel_c;

	always_comb begin
		// linear region only strictly between near and far
		if (dist_s4 >= QW'(side_s4.far_d)) begin
			gsel_c = GAIN_ZERO;
		end else if (dist_s4 > QW'(side_s4.near_d)) begin
			gsel_c = GAIN_DIV;
		end else begin
			gsel_c = GAIN_ONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		side_s5.invalid <= side_s4.invalid;
		side_s5.neg     <= side_s4.neg;
		side_s5.zero    <= zero_s4;
		// cosine at or above unity
		side_s5.sat     <= den_s4 <= PDW'(side_s4.dot);
		side_s5.gsel    <= gsel_c;
		side_s5.b       <= side_s4.b;
		pan_s5.rem      <= PNW'({side_s4.dot, 14'b0});
		pan_s5.den      <= den_s4;
		pan_s5.q        <= '0;
		gain_s5.rem     <= GNW'({side_s4.far_d - dist_s4[DW-1:0], 14'b0});
		gain_s5.den     <= side_s4.far_d - side_s4.near_d;
		gain_s5.q       <= '0;
	end

	// ---------------- divider row, one quotient bit per cell, msb first
	logic                 dv_v  [0:DQW];
	spdg_pkg::dv_side_t   dv_sd [0:DQW];
	spdg_pkg::pan_lane_t  dv_p  [0:DQW];
	spdg_pkg::gain_lane_t dv_g  [0:DQW];

	always_comb begin
		dv_v[0]  = v_s5;
		dv_sd[0] = side_s5;
		dv_p[0]  = pan_s5;
		dv_g[0]  = gain_s5;
	end

	for (genvar j = 0; j < DQW; j++) begin : g_div
		spdg_div_cell #(
			.BIT(DQW - 1 - j)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (dv_v[j]),
			.in_side  (dv_sd[j]),
			.in_pan   (dv_p[j]),
			.in_gain  (dv_g[j]),
			.out_valid(dv_v[j+1]),
			.out_side (dv_sd[j+1]),
			.out_pan  (dv_p[j+1]),
			.out_gain (dv_g[j+1])
		);
	end

	// ---------------- output stage: blend scaling and result register
	spdg_pkg::dv_side_t fs;
	logic        [BW-1:0] cos_c, g_c, pmag_c, gain_c;
	logic          [29:0] pprod_c, gprod_c;
	logic signed   [15:0] pan_c;

	always_comb begin
		fs      = dv_sd[DQW];
		cos_c   = fs.sat ? BW'(spdg_pkg::ONE_Q14) : BW'(dv_p[DQW].q);
		pprod_c = 30'(cos_c) * 30'(fs.b);
		pmag_c  = pprod_c[28:14];
		if (fs.zero) begin
			pan_c = '0;
		end else if (fs.neg) begin
			pan_c = -$signed(16'(pmag_c));
		end else begin
			pan_c = $signed(16'(pmag_c));
		end
		case (fs.gsel)
			GAIN_ZERO: g_c = '0;
			GAIN_DIV:  g_c = BW'(dv_g[DQW].q);
			GAIN_ONE:  g_c = BW'(spdg_pkg::ONE_Q14);
			default:   g_c = BW'(spdg_pkg::ONE_Q14);
		endcase
		// blend the gain toward unity
		gprod_c = 30'(BW'(spdg_pkg::ONE_Q14) - g_c) * 30'(fs.b);
		gain_c  = BW'(spdg_pkg::ONE_Q14) - gprod_c[28:14];
	end

	logic               done_q;
	logic signed [15:0] pan_q;
	logic      [BW-1:0] gain_q;
	logic               inv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_v[DQW];
		end
	end

	always_ff @(posedge clk) begin
		// bad distances force the neutral result
		if (fs.invalid) begin
			pan_q  <= '0;
			gain_q <= BW'(spdg_pkg::ONE_Q14);
			inv_q  <= 1'b1;
		end else begin
			pan_q  <= pan_c;
			gain_q <= gain_c;
			inv_q  <= 1'b0;
		end
	end

	assign done           = done_q;
	assign pan            = pan_q;
	assign distance_gain  = gain_q;
	assign params_invalid = inv_q;

`ifndef ASSERT_OFF
	// every beat taken comes out after the fixed pipe depth
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LATENCY done)
		else $error("result beat missing after pipe latency");

	// a flagged result is the neutral one
	a_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		(done && params_invalid) |-> (pan == 16'sd0 && distance_gain == 15'd16384))
		else $error("invalid parameters gave non-neutral result");

	// pan stays within full left and full right
	a_pan_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (pan >= -16'sd16384 && pan <= 16'sd16384))
		else $error("pan out of range");

	// gain never exceeds unity
	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (distance_gain <= 15'd16384))
		else $error("distance gain above unity");
`endif

endmodule
